// ===== hdl/rgbhsv_pkg.sv =====
// Shared types, constants and the divider step function for the RGB to HSV converter.
// Used by rgbhsv_div and rgb_to_hsv_fixed_point; depends on nothing else.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Pixel in and converted result out.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } out_t;

  // Hue sector, chosen by which component holds the maximum (red first).
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // Quotient bits produced by the divider.
  localparam int SAT_STEPS    = 9;
  localparam int HUE_STEPS    = 4;
  // Registers from the accepting edge to the edge that takes the result:
  // input register, divider stages, multiply register and output register.
  localparam int PIPE_LATENCY = SAT_STEPS + 3;

  // Sector offsets in units of 1/8 sector (offset 2 and 4 with 3 fraction bits).
  localparam logic [5:0] OFF_RED   = 6'd0;
  localparam logic [5:0] OFF_GREEN = 6'd16;
  localparam logic [5:0] OFF_BLUE  = 6'd32;

  localparam logic [6:0]         SAT_SCALE = 7'd100;
  localparam logic [14:0]        SAT_ROUND = 15'd128;
  localparam logic [4:0]         BRI_SCALE = 5'd25;
  localparam logic [12:0]        BRI_ROUND = 13'd32;
  localparam logic signed [12:0] HUE_SCALE = 13'sd60;
  localparam logic signed [12:0] HUE_WRAP  = 13'sd2880;
  localparam logic [12:0]        HUE_ROUND = 13'd4;

  // One stage of the two long divisions, moving down the divider pipeline.
  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [7:0] mx;
    logic [7:0] delta;
    logic       sbit;   // last dividend bit for the saturation division
    logic [7:0] srem;
    logic [8:0] squo;
    logic       hneg;   // hue numerator was negative
    logic       hbit;   // last dividend bit for the hue division
    logic [7:0] hrem;
    logic [3:0] hquo;
  } div_stage_t;

  // One restoring step: saturation divides by mx, hue by delta.
  function automatic div_stage_t div_step(div_stage_t s, logic first_step, logic hue_step);
    div_stage_t t;
    logic [8:0] sp;
    logic [8:0] hp;
    t  = s;
    sp = {s.srem, first_step ? s.sbit : 1'b0};
    if (sp >= {1'b0, s.mx}) begin
      t.srem = 8'(sp - {1'b0, s.mx});
      t.squo = {s.squo[7:0], 1'b1};
    end else begin
      t.srem = sp[7:0];
      t.squo = {s.squo[7:0], 1'b0};
    end
    if (hue_step) begin
      hp = {s.hrem, first_step ? s.hbit : 1'b0};
      if (hp >= {1'b0, s.delta}) begin
        t.hrem = 8'(hp - {1'b0, s.delta});
        t.hquo = {s.hquo[2:0], 1'b1};
      end else begin
        t.hrem = hp[7:0];
        t.hquo = {s.hquo[2:0], 1'b0};
      end
    end
    return t;
  endfunction

endpackage

// ===== hdl/rgbhsv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for saturation, and for hue in the first HUE_STEPS stages.
// Depends on rgbhsv_pkg for the stage struct and the step function.
`timescale 1ns / 1ps

module rgbhsv_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rgbhsv_pkg::div_stage_t div_in,
  output rgbhsv_pkg::div_stage_t div_out
);

  rgbhsv_pkg::div_stage_t st_r [rgbhsv_pkg::SAT_STEPS];

  // Each stage takes the previous one and resolves one more quotient bit.
  for (genvar k = 0; k < rgbhsv_pkg::SAT_STEPS; k++) begin : g_step
    rgbhsv_pkg::div_stage_t st_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        st_nxt = rgbhsv_pkg::div_step(div_in, 1'b1, 1'b1);
      end
    end else begin : g_rest
      always_comb begin
        st_nxt = rgbhsv_pkg::div_step(st_r[k-1], 1'b0, 1'(k < rgbhsv_pkg::HUE_STEPS));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].valid <= 1'b0;
      end else begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign div_out = st_r[rgbhsv_pkg::SAT_STEPS-1];

endmodule

// ===== hdl/rgb_to_hsv_fixed_point.sv =====
// RGB to HSV converter top level: input register, sector decode, divider, scaling.
// Depends on rgbhsv_pkg and rgbhsv_div.
// Pipeline: input register, divider stages, multiply register, output register; out_valid comes from the last.
// Throughput: one pixel per clock; busy is always low since the results cannot be held off.
// The divider has 9 stages, one quotient bit per stage, and is fully pipelined.
// Reset is synchronous and active low; it clears the valid bits of every stage.
`timescale 1ns / 1ps

module rgb_to_hsv_fixed_point (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rgbhsv_pkg::in_t  in_pixel,
  output logic             out_valid,
  output rgbhsv_pkg::out_t out_pixel
);

  // Input register.
  logic            a_valid_r;
  rgbhsv_pkg::in_t a_pix_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_pix_r <= in_pixel;
    end
  end

  // Max, min, sector and signed hue numerator.
  logic [7:0]             mx;
  logic [7:0]             mn;
  logic [7:0]             pa;
  logic [7:0]             pb;
  logic [8:0]             num;
  logic [7:0]             num_abs;
  rgbhsv_pkg::sector_t    sector;
  rgbhsv_pkg::div_stage_t div_in;
  rgbhsv_pkg::div_stage_t div_out;

  always_comb begin
    mx = (a_pix_r.red > a_pix_r.green) ? a_pix_r.red : a_pix_r.green;
    mx = (mx > a_pix_r.blue) ? mx : a_pix_r.blue;
    mn = (a_pix_r.red < a_pix_r.green) ? a_pix_r.red : a_pix_r.green;
    mn = (mn < a_pix_r.blue) ? mn : a_pix_r.blue;
    if (a_pix_r.red == mx) begin
      sector = rgbhsv_pkg::SECT_RED;
      pa     = a_pix_r.green;
      pb     = a_pix_r.blue;
    end else if (a_pix_r.green == mx) begin
      sector = rgbhsv_pkg::SECT_GREEN;
      pa     = a_pix_r.blue;
      pb     = a_pix_r.red;
    end else begin
      sector = rgbhsv_pkg::SECT_BLUE;
      pa     = a_pix_r.red;
      pb     = a_pix_r.green;
    end
    num     = {1'b0, pa} - {1'b0, pb};
    num_abs = num[8] ? 8'(-num) : num[7:0];

    div_in.valid  = a_valid_r;
    div_in.sector = sector;
    div_in.mx     = mx;
    div_in.delta  = mx - mn;
    // The top dividend bits go straight into the remainder; they stay below the divisor.
    div_in.sbit   = div_in.delta[0];
    div_in.srem   = {1'b0, div_in.delta[7:1]};
    div_in.squo   = '0;
    div_in.hneg   = num[8];
    div_in.hbit   = num_abs[0];
    div_in.hrem   = {1'b0, num_abs[7:1]};
    div_in.hquo   = '0;
  end

  rgbhsv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_in),
    .div_out (div_out)
  );

  // Signed hue in eighths of a sector; negative quotients round toward minus infinity.
  logic [4:0]        qmag;
  logic signed [5:0] qs;
  logic [5:0]        off;
  logic signed [6:0] h3;

  always_comb begin
    qmag = {1'b0, div_out.hquo} + {4'b0, (div_out.hneg && div_out.hrem != 8'd0)};
    qs   = div_out.hneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    unique case (div_out.sector)
      rgbhsv_pkg::SECT_RED:   off = rgbhsv_pkg::OFF_RED;
      rgbhsv_pkg::SECT_GREEN: off = rgbhsv_pkg::OFF_GREEN;
      rgbhsv_pkg::SECT_BLUE:  off = rgbhsv_pkg::OFF_BLUE;
      default:                off = rgbhsv_pkg::OFF_RED;
    endcase
    h3 = $signed({1'b0, off}) + 7'(qs);
  end

  // Scaling multiplies.
  logic               b_valid_r;
  logic               b_grey_r;
  logic [14:0]        b_sat_r;
  logic [12:0]        b_bri_r;
  logic signed [12:0] b_hue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    b_grey_r <= (div_out.delta == 8'd0);
    b_sat_r  <= 15'(div_out.squo * rgbhsv_pkg::SAT_SCALE) + rgbhsv_pkg::SAT_ROUND;
    b_bri_r  <= 13'(div_out.mx * rgbhsv_pkg::BRI_SCALE) + rgbhsv_pkg::BRI_ROUND;
    b_hue_r  <= 13'(h3) * rgbhsv_pkg::HUE_SCALE;
  end

  // Wrap, round and register the result.
  logic               c_valid_r;
  rgbhsv_pkg::out_t   c_out_r;
  rgbhsv_pkg::out_t   c_out_nxt;
  logic signed [12:0] hwrap;
  logic [12:0]        hround;

  always_comb begin
    hwrap  = b_hue_r[12] ? b_hue_r + rgbhsv_pkg::HUE_WRAP : b_hue_r;
    hround = 13'(hwrap) + rgbhsv_pkg::HUE_ROUND;
    c_out_nxt.brightness = b_bri_r[12:6];
    if (b_grey_r) begin
      c_out_nxt.hue        = '0;
      c_out_nxt.saturation = '0;
    end else begin
      c_out_nxt.hue        = hround[11:3];
      c_out_nxt.saturation = b_sat_r[14:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_out_r <= c_out_nxt;
  end

  assign out_valid = c_valid_r;
  assign out_pixel = c_out_r;

`ifndef NO_ASSERTIONS
  // Every accepted pixel produces a result after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(rgbhsv_pkg::PIPE_LATENCY) out_valid)
    else $error("accepted pixel produced no result at the expected cycle");

  // No result appears without a pixel accepted the fixed latency earlier.
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rgbhsv_pkg::PIPE_LATENCY))
    else $error("result without a matching accepted pixel");

  // Results stay in their ranges.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel.hue <= 9'd360 && out_pixel.saturation <= 7'd100 &&
                   out_pixel.brightness <= 7'd100))
    else $error("result field out of range");
`endif

endmodule
